// ----- hw/rtl/rpv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpv_pkg
// Constants, byte codes, state type and character helpers shared by the
// request path validator.
// ----------------------------------------------------------------------------
package rpv_pkg;

    localparam int MAX_PATH_LEN = 384;
    localparam int CNT_W        = $clog2(MAX_PATH_LEN + 2);

    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_LOW_A    = 8'h61;
    localparam logic [7:0] CH_LOW_Z    = 8'h7A;
    localparam logic [7:0] CH_UP_A     = 8'h41;
    localparam logic [7:0] CH_UP_Z     = 8'h5A;
    localparam logic [7:0] CH_DIG_0    = 8'h30;
    localparam logic [7:0] CH_DIG_9    = 8'h39;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PATH_LEN);

    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic             rejected;
        logic             in_query;
        logic [1:0]       segment_length;
        logic             segment_all_dots;
        logic             at_key_start;
    } rpv_state_t;

    localparam rpv_state_t STATE_RESET = '{
        byte_count:       '0,
        rejected:         1'b0,
        in_query:         1'b0,
        segment_length:   2'd0,
        segment_all_dots: 1'b1,
        at_key_start:     1'b0
    };

    function automatic logic is_unreserved(input logic [7:0] c);
        is_unreserved = (c >= CH_LOW_A && c <= CH_LOW_Z)
                     || (c >= CH_UP_A  && c <= CH_UP_Z)
                     || (c >= CH_DIG_0 && c <= CH_DIG_9)
                     || c == CH_DASH || c == CH_UNDER
                     || c == CH_DOT  || c == CH_TILDE;
    endfunction

    function automatic logic segment_bad(input logic [1:0] len, input logic all_dots);
        segment_bad = (len == 2'd0) || (all_dots && len <= 2'd2);
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rpv_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rpv_step
// Per-byte state update and final verdict for one path byte.
// ----------------------------------------------------------------------------
module rpv_step
    import rpv_pkg::*;
(
    input  wire rpv_state_t  state,
    input  wire logic [7:0]  char_byte,
    input  wire logic        end_of_path,
    output rpv_state_t       state_next,
    output logic             path_ok
);

    rpv_state_t upd;
    logic       rej_final;

    always_comb
    begin
        upd = state;
        if (state.byte_count == '0)
        begin
            if (char_byte != CH_SLASH)
            begin
                upd.rejected = 1'b1;
            end
            upd.segment_length   = 2'd0;
            upd.segment_all_dots = 1'b1;
        end
        else if (!state.in_query)
        begin
            if (char_byte == CH_SLASH || char_byte == CH_QUESTION)
            begin
                if (segment_bad(state.segment_length, state.segment_all_dots))
                begin
                    upd.rejected = 1'b1;
                end
                upd.segment_length   = 2'd0;
                upd.segment_all_dots = 1'b1;
                if (char_byte == CH_QUESTION)
                begin
                    upd.in_query     = 1'b1;
                    upd.at_key_start = 1'b1;
                end
            end
            else if (is_unreserved(char_byte))
            begin
                if (state.segment_length != 2'd3)
                begin
                    upd.segment_length = state.segment_length + 2'd1;
                end
                if (char_byte != CH_DOT)
                begin
                    upd.segment_all_dots = 1'b0;
                end
            end
            else
            begin
                upd.rejected = 1'b1;
            end
        end
        else
        begin
            if (char_byte == CH_AMP || char_byte == CH_EQUAL)
            begin
                if (state.at_key_start)
                begin
                    upd.rejected = 1'b1;
                end
                if (char_byte == CH_AMP)
                begin
                    upd.at_key_start = 1'b1;
                end
            end
            else if (is_unreserved(char_byte) || char_byte == CH_PERCENT)
            begin
                upd.at_key_start = 1'b0;
            end
            else
            begin
                upd.rejected = 1'b1;
            end
        end

        if (state.byte_count <= CNT_MAX)
        begin
            upd.byte_count = state.byte_count + CNT_W'(1);
        end

        rej_final = upd.rejected || (upd.byte_count > CNT_MAX);
        if (!upd.in_query)
        begin
            rej_final = rej_final || segment_bad(upd.segment_length, upd.segment_all_dots);
        end
        else
        begin
            rej_final = rej_final || upd.at_key_start;
        end

        path_ok    = !rej_final;
        state_next = end_of_path ? STATE_RESET : upd;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/request_path_validator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// request_path_validator
// Checks a request path streamed one byte per item and reports on the final
// byte whether the path is acceptable.
// ----------------------------------------------------------------------------
// Accepts one byte every clock cycle while in_stall is low. Each byte lands in
// an input register; the path state is updated from it as it moves on, and on
// a final byte the verdict is written to the result register with it, so
// path_ok is valid once the final byte has left the input register. The input
// side stalls only while a verdict is ready to move and the result register is
// still held by a stalled consumer. Bytes that are not final produce no result item.
module request_path_validator
    import rpv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_byte,
    input  wire logic       end_of_path,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            path_ok
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    rpv_state_t st_reg;
    rpv_state_t st_next;
    logic       ok_next;
    logic       out_valid_reg;
    logic       path_ok_reg;
    logic       out_free;
    logic       s1_adv;
    logic       in_acc;

    rpv_step u_step (
        .state       (st_reg),
        .char_byte   (s1_byte_reg),
        .end_of_path (s1_last_reg),
        .state_next  (st_next),
        .path_ok     (ok_next)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign path_ok   = path_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            st_reg        <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                st_reg <= st_next;
            end
            if (s1_adv && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_byte_reg <= char_byte;
            s1_last_reg <= end_of_path;
        end
        if (s1_adv && s1_last_reg)
        begin
            path_ok_reg <= ok_next;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.byte_count <= CNT_MAX + CNT_W'(1))
        else $error("byte count ran past its saturation point");

    a_query_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.in_query |-> st_reg.byte_count > CNT_W'(1))
        else $error("query flag set without a leading path");

    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_last_reg |=> st_reg.byte_count == '0 && !st_reg.rejected
            && !st_reg.in_query)
        else $error("path state not cleared after final byte");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !$past(out_valid_reg) |-> $past(s1_adv && s1_last_reg))
        else $error("result produced without a final byte");

endmodule
`default_nettype wire

// ----- verif/tb_request_path_validator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_request_path_validator
// Self-checking bench for the request path validator. Paths are streamed one
// byte per item, with random gaps on the input side and random stalls on the
// result side. A behavioral path checker kept in the bench predicts the
// verdict for every final byte. Each verdict the block returns is compared
// with the oldest one still pending.
// ----------------------------------------------------------------------------
module tb_request_path_validator;
    import rpv_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_byte;
    logic       end_of_path;
    logic       out_valid;
    logic       out_stall;
    logic       path_ok;

    request_path_validator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_byte   (char_byte),
        .end_of_path (end_of_path),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .path_ok     (path_ok)
    );

    always #4 clk = ~clk;

    bit [CNT_W-1:0] pk_count;
    bit             pk_rejected;
    bit             pk_in_query;
    bit [1:0]       pk_seg_len;
    bit             pk_seg_dots;
    bit             pk_key_start;

    bit [7:0] path_buf[$];
    bit       verdict_q[$];
    int       err_count   = 0;
    int       byte_total  = 0;
    int       path_total  = 0;
    int       ok_seen     = 0;
    int       bad_seen    = 0;
    int       tx_idle_pct = 0;
    int       rx_stall_pct = 0;
    int       stall_left  = 0;

    function automatic void path_state_clear();
        pk_count     = '0;
        pk_rejected  = 1'b0;
        pk_in_query  = 1'b0;
        pk_seg_len   = 2'd0;
        pk_seg_dots  = 1'b1;
        pk_key_start = 1'b0;
    endfunction

    function automatic bit plain_char(input bit [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z)
            || (c >= CH_DIG_0 && c <= CH_DIG_9) || c == CH_DASH || c == CH_UNDER
            || c == CH_DOT || c == CH_TILDE;
    endfunction

    function automatic bit seg_broken();
        return pk_seg_len == 2'd0 || (pk_seg_dots && pk_seg_len <= 2'd2);
    endfunction

    function automatic void predict_byte(input bit [7:0] c, input bit last,
                                         output bit has_verdict, output bit verdict);
        has_verdict = 1'b0;
        verdict     = 1'b0;
        if (pk_count == 0)
        begin
            if (c != CH_SLASH)
                pk_rejected = 1'b1;
            pk_seg_len  = 2'd0;
            pk_seg_dots = 1'b1;
        end
        else if (!pk_in_query)
        begin
            if (c == CH_SLASH || c == CH_QUESTION)
            begin
                if (seg_broken())
                    pk_rejected = 1'b1;
                pk_seg_len  = 2'd0;
                pk_seg_dots = 1'b1;
                if (c == CH_QUESTION)
                begin
                    pk_in_query  = 1'b1;
                    pk_key_start = 1'b1;
                end
            end
            else if (plain_char(c))
            begin
                if (pk_seg_len != 2'd3)
                    pk_seg_len = pk_seg_len + 2'd1;
                if (c != CH_DOT)
                    pk_seg_dots = 1'b0;
            end
            else
                pk_rejected = 1'b1;
        end
        else
        begin
            if (c == CH_AMP || c == CH_EQUAL)
            begin
                if (pk_key_start)
                    pk_rejected = 1'b1;
                if (c == CH_AMP)
                    pk_key_start = 1'b1;
            end
            else if (plain_char(c) || c == CH_PERCENT)
                pk_key_start = 1'b0;
            else
                pk_rejected = 1'b1;
        end
        if (pk_count <= MAX_PATH_LEN)
            pk_count = pk_count + 1'b1;
        if (last)
        begin
            if (pk_count > MAX_PATH_LEN)
                pk_rejected = 1'b1;
            if (!pk_in_query)
            begin
                if (seg_broken())
                    pk_rejected = 1'b1;
            end
            else if (pk_key_start)
                pk_rejected = 1'b1;
            has_verdict = 1'b1;
            verdict     = !pk_rejected;
            path_state_clear();
        end
    endfunction

    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(99) < rx_stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("unexpected result item: path_ok=%0b", path_ok);
                err_count++;
            end
            else
            begin
                bit want;
                want = verdict_q.pop_front();
                if (path_ok !== want)
                begin
                    $error("path_ok mismatch: expected %0b, actual %0b", want, path_ok);
                    err_count++;
                end
                if (want)
                    ok_seen++;
                else
                    bad_seen++;
            end
        end
    end

    task automatic send_byte(input bit [7:0] c, input bit last);
        bit has_v;
        bit v;
        bit ready;
        int gap;
        in_valid    <= 1'b1;
        char_byte   <= c;
        end_of_path <= last;
        do
        begin
            @(negedge clk);
            ready = !in_stall;
            @(posedge clk);
        end
        while (!ready);
        predict_byte(c, last, has_v, v);
        if (has_v)
        begin
            verdict_q.push_back(v);
            path_total++;
        end
        byte_total++;
        gap = pick_gap(tx_idle_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_path();
        for (int i = 0; i < path_buf.size(); i++)
            send_byte(path_buf[i], i == path_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        path_buf.delete();
        for (int i = 0; i < s.len(); i++)
            path_buf.push_back(s[i]);
        send_path();
    endtask

    function automatic bit [7:0] pick_plain();
        case ($urandom_range(0, 9))
            0, 1, 2: return CH_LOW_A + 8'($urandom_range(0, 25));
            3, 4:    return CH_UP_A + 8'($urandom_range(0, 25));
            5, 6:    return CH_DIG_0 + 8'($urandom_range(0, 9));
            7:       return CH_DASH;
            8:       return CH_UNDER;
            default: return $urandom_range(1) ? CH_DOT : CH_TILDE;
        endcase
    endfunction

    function automatic bit [7:0] pick_query();
        case ($urandom_range(0, 11))
            0:       return CH_PERCENT;
            1:       return CH_EQUAL;
            default: return pick_plain();
        endcase
    endfunction

    function automatic void build_random_path();
        int n;
        int pos;
        bit [7:0] marks[4];
        marks = '{CH_QUESTION, CH_SLASH, CH_AMP, CH_EQUAL};
        path_buf.delete();
        if ($urandom_range(99) < 8)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                path_buf.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(1))
                path_buf[0] = CH_SLASH;
            return;
        end
        path_buf.push_back(CH_SLASH);
        n = $urandom_range(1, 4);
        for (int s = 0; s < n; s++)
        begin
            case ($urandom_range(0, 19))
                0: path_buf.push_back(CH_DOT);
                1: path_buf = {path_buf, CH_DOT, CH_DOT};
                2: path_buf = {path_buf, CH_DOT, CH_DOT, CH_DOT};
                3: ;
                default:
                begin
                    int len;
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        path_buf.push_back(pick_plain());
                end
            endcase
            if (s != n - 1)
                path_buf.push_back(CH_SLASH);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            int pairs;
            path_buf.push_back(CH_QUESTION);
            pairs = $urandom_range(1, 3);
            for (int p = 0; p < pairs; p++)
            begin
                int klen;
                int vlen;
                if (p > 0)
                    path_buf.push_back(CH_AMP);
                klen = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
                for (int i = 0; i < klen; i++)
                    path_buf.push_back(pick_query());
                if ($urandom_range(1))
                begin
                    path_buf.push_back(CH_EQUAL);
                    vlen = $urandom_range(0, 4);
                    for (int i = 0; i < vlen; i++)
                        path_buf.push_back(pick_query());
                end
            end
            if ($urandom_range(0, 15) == 0)
                path_buf.push_back(CH_AMP);
        end
        if ($urandom_range(99) < 20)
        begin
            pos = $urandom_range(0, path_buf.size() - 1);
            case ($urandom_range(0, 3))
                0: path_buf[pos] = 8'($urandom_range(0, 255));
                1: path_buf.insert(pos, marks[$urandom_range(0, 3)]);
                2: if (path_buf.size() > 1) path_buf.delete(pos);
                default: path_buf[pos] = 8'($urandom_range(128, 255));
            endcase
        end
    endfunction

    function automatic void build_long_path(input int n);
        path_buf.delete();
        path_buf.push_back(CH_SLASH);
        for (int i = 1; i < n; i++)
            path_buf.push_back((i % 10 == 0 && i != n - 1) ? CH_SLASH : pick_plain());
        for (int i = 1; i < n; i++)
            if (path_buf[i] == CH_DOT)
                path_buf[i] = CH_TILDE;
    endfunction

    task automatic test_directed_cases();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_text("/");
        send_byte(8'h00, 1'b1);
        send_text("/..");
        send_text("/~?&");
        send_text("/A?=%?");
        send_text("/z-?a=%&0");
        send_byte(CH_SLASH, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_length_limit();
        int lens[2];
        lens = '{MAX_PATH_LEN, 520};
        tx_idle_pct  = 15;
        rx_stall_pct = 20;
        foreach (lens[i])
        begin
            build_long_path(lens[i]);
            send_path();
        end
    endtask

    task automatic test_random_paths();
        int start;
        int idle_mix[3];
        int stall_mix[3];
        idle_mix  = '{30, 0, 10};
        stall_mix = '{30, 0, 60};
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct  = idle_mix[ph];
            rx_stall_pct = stall_mix[ph];
            start = byte_total;
            while (byte_total - start < 105)
            begin
                build_random_path();
                send_path();
            end
        end
    endtask

    initial
    begin
        int waited;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        char_byte   <= 8'h00;
        end_of_path <= 1'b0;
        path_state_clear();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_length_limit();
        test_random_paths();
        in_valid <= 1'b0;

        for (waited = 0; verdict_q.size() != 0 && waited < 5000; waited++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            $error("%0d verdicts never arrived", verdict_q.size());
            err_count++;
        end

        $display("Streamed %0d bytes forming %0d paths with random gaps and stalls.",
                 byte_total, path_total);
        $display("Verdicts checked: %0d accepted paths, %0d rejected paths.",
                 ok_seen, bad_seen);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
